@@ hdl/generational_slot_allocator_unit_macros.svh @@
// Assertion macros for the generational slot allocator.
// Included by generational_slot_allocator_unit, which checks its own logic; no other dependencies.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define GSA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define GSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define GSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GSA_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define GSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/gsa_pkg.sv @@
// Shared types and constants for the generational slot allocator.
// No dependencies; used by generational_slot_allocator_unit.
`default_nettype none

package gsa_pkg;

  // default table geometry
  localparam int SLOT_COUNT_DEF = 256;
  localparam int GEN_BITS_DEF   = 16;

  // fixed transaction field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 8;
  localparam int GEN_W = 16;
  localparam int ST_W  = 2;

  // request operation codes; the unused code behaves as lookup
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_STALE = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ hdl/gsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the generation table and the free stack.
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/generational_slot_allocator_unit.sv @@
// An accepted transaction passes the execute stage, then the output register.
// Throughput: one transaction per cycle; the execute stage reads the generation
// RAM and free-stack RAM (registered reads) issued at accept, with forwarding.
// Output stall holds the execute stage and back-pressures the input.
// Reset (synchronous, rst_n low) clears counters, live bits and valids at once;
// the RAMs are not cleared and need no clearing pass.
`default_nettype none
`include "generational_slot_allocator_unit_macros.svh"

module generational_slot_allocator_unit #(
  parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request channel
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [gsa_pkg::OP_W-1:0]  in_operation,
  input  wire logic [gsa_pkg::IDX_W-1:0] in_slot_index,
  input  wire logic [gsa_pkg::GEN_W-1:0] in_generation,
  // result channel
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic [gsa_pkg::ST_W-1:0]  out_status,
  output      logic [gsa_pkg::IDX_W-1:0] out_handle_slot,
  output      logic [gsa_pkg::GEN_W-1:0] out_handle_generation
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CW     = SLOT_W + 1;
  localparam int STK_W  = GEN_BITS + SLOT_W;
  localparam int EXT_W  = (gsa_pkg::IDX_W > CW) ? gsa_pkg::IDX_W : CW;
  localparam int CMP_W  = (GEN_BITS > gsa_pkg::GEN_W) ? GEN_BITS : gsa_pkg::GEN_W;

  // handshake
  logic in_accept;
  logic out_ready;
  logic ex_fire;

  // execute stage
  logic                      ex_valid_r;
  logic [gsa_pkg::OP_W-1:0]  ex_op_r;
  logic [gsa_pkg::IDX_W-1:0] ex_idx_r;
  logic [gsa_pkg::GEN_W-1:0] ex_gen_r;

  // allocator state
  logic [SLOT_COUNT-1:0] live_r;
  logic [CW-1:0]         fc_r;
  logic [CW-1:0]         fc_nxt;
  logic [CW-1:0]         used_r;
  logic [CW-1:0]         used_nxt;

  // RAM ports and read forwarding
  logic                gen_we;
  logic [SLOT_W-1:0]   gen_waddr;
  logic [GEN_BITS-1:0] gen_wdata;
  logic [SLOT_W-1:0]   gen_raddr;
  logic [GEN_BITS-1:0] gen_rdata;
  logic                gen_byp_r;
  logic [GEN_BITS-1:0] gen_byp_data_r;
  logic [GEN_BITS-1:0] gen_cur;
  logic                stk_we;
  logic [SLOT_W-1:0]   stk_waddr;
  logic [STK_W-1:0]    stk_wdata;
  logic [SLOT_W-1:0]   stk_raddr;
  logic [STK_W-1:0]    stk_rdata;
  logic                stk_byp_r;
  logic [STK_W-1:0]    stk_byp_data_r;
  logic [STK_W-1:0]    stk_cur;
  logic [CW-1:0]       fc_dec;

  // execute results
  logic [SLOT_W-1:0]       slot_sel;
  logic                    in_range;
  logic                    handle_ok;
  logic [gsa_pkg::ST_W-1:0] chk_st;
  logic [gsa_pkg::ST_W-1:0] res_st;
  logic [SLOT_W-1:0]       res_slot;
  logic [gsa_pkg::IDX_W-1:0] res_idx;
  logic [GEN_BITS-1:0]     res_gen;
  logic [GEN_BITS-1:0]     pop_gen;
  logic [GEN_BITS-1:0]     bump_gen;
  logic                    alloc_ok;
  logic                    live_we;
  logic                    live_val;

  // output register
  logic                      out_valid_r;
  logic [gsa_pkg::ST_W-1:0]  out_status_r;
  logic [gsa_pkg::IDX_W-1:0] out_slot_r;
  logic [gsa_pkg::GEN_W-1:0] out_gen_r;

  // handshake: execute stage advances when the output register can take it
  assign out_ready = !out_valid_r || !out_stall;
  assign ex_fire   = ex_valid_r && out_ready;
  assign in_stall  = ex_valid_r && !ex_fire;
  assign in_accept = in_valid && !in_stall;

  // the free-stack read address follows the state after the executing transaction
  assign fc_dec    = fc_nxt - CW'(1);
  assign gen_raddr = SLOT_W'(in_slot_index);
  assign stk_raddr = fc_dec[SLOT_W-1:0];

  // select forwarded data where the previous transaction wrote the same entry
  assign gen_cur = gen_byp_r ? gen_byp_data_r : gen_rdata;
  assign stk_cur = stk_byp_r ? stk_byp_data_r : stk_rdata;

  // handle check for free and lookup
  assign slot_sel  = SLOT_W'(ex_idx_r);
  assign in_range  = EXT_W'(ex_idx_r) < EXT_W'(used_r);
  assign handle_ok = live_r[slot_sel] && (CMP_W'(gen_cur) == CMP_W'(ex_gen_r));
  assign chk_st    = !in_range  ? gsa_pkg::ST_RANGE :
                     !handle_ok ? gsa_pkg::ST_STALE : gsa_pkg::ST_OK;

  assign pop_gen  = stk_cur[STK_W-1:SLOT_W] + GEN_BITS'(1);
  assign bump_gen = gen_cur + GEN_BITS'(1);

  // execute one transaction and form the state updates
  always_comb begin
    res_st    = gsa_pkg::ST_OK;
    res_slot  = slot_sel;
    res_idx   = ex_idx_r;
    res_gen   = '0;
    alloc_ok  = 1'b0;
    gen_we    = 1'b0;
    gen_waddr = slot_sel;
    gen_wdata = '0;
    stk_we    = 1'b0;
    stk_waddr = fc_r[SLOT_W-1:0];
    stk_wdata = {bump_gen, slot_sel};
    live_we   = 1'b0;
    live_val  = 1'b0;
    fc_nxt    = fc_r;
    used_nxt  = used_r;
    unique case (ex_op_r)
      gsa_pkg::OP_ALLOC: begin
        if (fc_r != '0) begin
          // reuse the most recently freed slot
          alloc_ok  = 1'b1;
          res_slot  = stk_cur[SLOT_W-1:0];
          res_gen   = pop_gen;
          gen_we    = ex_fire;
          gen_waddr = stk_cur[SLOT_W-1:0];
          gen_wdata = pop_gen;
          live_we   = ex_fire;
          live_val  = 1'b1;
          fc_nxt    = ex_fire ? fc_r - CW'(1) : fc_r;
        end else if (used_r < CW'(SLOT_COUNT)) begin
          // take a never-used slot at generation zero
          alloc_ok  = 1'b1;
          res_slot  = used_r[SLOT_W-1:0];
          gen_we    = ex_fire;
          gen_waddr = used_r[SLOT_W-1:0];
          live_we   = ex_fire;
          live_val  = 1'b1;
          used_nxt  = ex_fire ? used_r + CW'(1) : used_r;
        end else begin
          res_st   = gsa_pkg::ST_FULL;
          res_slot = '0;
        end
        res_idx = gsa_pkg::IDX_W'(res_slot);
      end
      gsa_pkg::OP_FREE: begin
        res_st = chk_st;
        if (chk_st == gsa_pkg::ST_OK && fc_r < CW'(SLOT_COUNT)) begin
          // retire the handle and push the slot
          res_gen   = bump_gen;
          gen_we    = ex_fire;
          gen_wdata = bump_gen;
          stk_we    = ex_fire;
          live_we   = ex_fire;
          live_val  = 1'b0;
          fc_nxt    = ex_fire ? fc_r + CW'(1) : fc_r;
        end
      end
      default: begin
        res_st = chk_st;
        if (chk_st == gsa_pkg::ST_OK) begin
          res_gen = gen_cur;
        end
      end
    endcase
  end

  // generation per slot
  gsa_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (in_accept),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  // free stack: slot with its already bumped generation
  gsa_ram #(
    .WIDTH (STK_W),
    .DEPTH (SLOT_COUNT)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (in_accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      fc_r        <= '0;
      used_r      <= '0;
      gen_byp_r   <= 1'b0;
      stk_byp_r   <= 1'b0;
    end else begin
      if (!in_stall) begin
        ex_valid_r <= in_valid;
      end
      if (out_ready) begin
        out_valid_r <= ex_valid_r;
      end
      if (live_we) begin
        live_r[res_slot] <= live_val;
      end
      fc_r   <= fc_nxt;
      used_r <= used_nxt;
      if (in_accept) begin
        gen_byp_r <= gen_we && (gen_waddr == gen_raddr);
        stk_byp_r <= stk_we && (stk_waddr == stk_raddr);
      end
    end
  end

  // capture the transaction, forwarded data and the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_op_r        <= in_operation;
      ex_idx_r       <= in_slot_index;
      ex_gen_r       <= in_generation;
      gen_byp_data_r <= gen_wdata;
      stk_byp_data_r <= stk_wdata;
    end
    if (ex_fire) begin
      out_status_r <= res_st;
      out_slot_r   <= res_idx;
      out_gen_r    <= gsa_pkg::GEN_W'(res_gen);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle_slot       = out_slot_r;
  assign out_handle_generation = out_gen_r;

  // the free stack never holds more slots than were ever handed out
  `GSA_ASSERT_ALWAYS(a_fc_le_used, clk, rst_n, fc_r <= used_r)
  // the high-water mark never falls
  `GSA_ASSERT_NEXT(a_used_mono, clk, rst_n, 1'b1, used_r >= $past(used_r))
  // a granted slot is live right after the transaction retires
  `GSA_ASSERT_NEXT(a_alloc_live, clk, rst_n, ex_fire && alloc_ok, live_r[$past(res_slot)])
  // the input is only held back by a waiting execute stage
  `GSA_ASSERT_IMPL(a_stall_src, clk, rst_n, in_stall, ex_valid_r && out_valid_r)

endmodule

`default_nettype wire
